// ===== rtl/ktu_pkg.sv =====
// ----------------------------------------------------------------------------
// ktu_pkg
// Types and constants shared by the Kalman track update block: the input and
// result item layouts, the item kind codes and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ktu_pkg;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // The reserved kind is accepted and ignored.
  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_END    = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_GATE     = 2'd0,
    REG_MAXMISS  = 2'd1,
    REG_ACCELVAR = 2'd2,
    REG_MEASVAR  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               has_measurement;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic [7:0]         miss_count;
    logic               had_detections;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               matched;
    logic [7:0]         new_miss_count;
    logic               drop;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/kalman_track_update.sv =====
// ----------------------------------------------------------------------------
// kalman_track_update
// Constant-velocity 2D Kalman tracker with one covariance shared by all tracks.
// ----------------------------------------------------------------------------
// Every multiply runs through one 32x32 signed multiplier feeding one
// accumulator under a small sequencer; the 2x2 inverse uses a restoring
// divider that retires one quotient bit per cycle. The block takes no new
// item until the current one is done; a finished result waits in the
// output register while the next item is accepted.
`default_nettype none

module kalman_track_update #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ktu_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ktu_pkg::out_t                   out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ktu_pkg::APB_AW-1:0] paddr,
  input  wire logic [ktu_pkg::APB_DW-1:0] pwdata,
  output logic [ktu_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int DW = 64 - FRAC_BITS;   // determinant magnitude
  localparam int NW = 33 + FRAC_BITS;   // scaled numerator
  localparam int CW = $clog2(NW + 1);
  localparam logic [30:0] GATE_RST = 31'(64'd20 << FRAC_BITS);
  localparam logic [30:0] VAR_RST  = 31'(64'd25 << (FRAC_BITS - 2));
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic [NW-1:0] Q_POS_MAX = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] Q_NEG_MAX = NW'(64'h8000_0000);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_PREP  = 15'b000000000000010,
    ST_GATE  = 15'b000000000000100,
    ST_CORR  = 15'b000000000001000,
    ST_OUT   = 15'b000000000010000,
    ST_PRED  = 15'b000000000100000,
    ST_COPYP = 15'b000000001000000,
    ST_SCALC = 15'b000000010000000,
    ST_DET   = 15'b000000100000000,
    ST_DIVLD = 15'b000001000000000,
    ST_DIV   = 15'b000010000000000,
    ST_DIVST = 15'b000100000000000,
    ST_GAIN  = 15'b001000000000000,
    ST_FEND  = 15'b010000000000000,
    ST_COPYE = 15'b100000000000000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] noise_w(input logic [3:0] idx,
                                                 input logic [30:0] a);
    logic signed [31:0] r;
    case (idx)
      4'd0, 4'd5:                r = {3'b000, a[30:2]};
      4'd10, 4'd15:              r = {1'b0, a};
      4'd2, 4'd7, 4'd8, 4'd13:   r = {2'b00, a[30:1]};
      default:                   r = '0;
    endcase
    return r;
  endfunction

  state_e state_q;

  logic [30:0] gate_q, accv_q, measv_q;
  logic [7:0]  maxm_q;

  logic signed [31:0] cov_q [16];
  logic signed [31:0] tmp_q [16];
  logic signed [31:0] gain_q [8];
  logic signed [31:0] inv_q [4];
  logic signed [31:0] x_q [4];
  logic signed [31:0] s00_q, s01_q, s10_q, s11_q;
  logic signed [31:0] dx_q, dy_q;

  ktu_pkg::in_t  item_q;
  ktu_pkg::out_t out_q;
  logic          out_valid_q;
  logic          matched_q;

  logic [3:0] elem_q;
  logic [2:0] step_q;
  logic signed [63:0] prod_q;
  logic               raw_q, neg_q;
  logic signed [65:0] acc_q;

  logic [DW-1:0] dmag_q;
  logic          det_neg_q;
  logic [1:0]    div_k_q;
  logic [NW-1:0] dq_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          qneg_q;

  // Operand selection for the shared multiplier.
  logic signed [31:0] mul_a, mul_b, cov_rd, gain_rd;
  logic [3:0]         cov_addr;
  logic [2:0]         gain_addr;
  logic               mul_raw, mul_neg, engine;
  logic [2:0]         nterms;
  logic [3:0]         nlast;
  logic [1:0]         pr_k, pr_l;
  logic               pr_ok;
  logic signed [63:0] prod_d;
  logic signed [65:0] term, acc_next;

  assign cov_rd  = cov_q[cov_addr];
  assign gain_rd = gain_q[gain_addr];
  assign prod_d  = mul_a * mul_b;
  assign term    = raw_q ? 66'(prod_q) : 66'(prod_q >>> FRAC_BITS);
  assign acc_next = neg_q ? acc_q - term : acc_q + term;

  always_comb begin
    mul_a     = '0;
    mul_b     = 32'sd1;
    mul_raw   = 1'b0;
    mul_neg   = 1'b0;
    cov_addr  = '0;
    gain_addr = '0;
    nterms    = 3'd2;
    nlast     = 4'd0;
    engine    = 1'b0;
    pr_k      = elem_q[3:2] + {step_q[1], 1'b0};
    pr_l      = elem_q[1:0] + {step_q[0], 1'b0};
    pr_ok     = (!step_q[1] || !elem_q[3]) && (!step_q[0] || !elem_q[1]);
    case (state_q)
      ST_PRED: begin
        // Sum of the A P A^T contributions, added through the multiplier.
        engine   = 1'b1;
        nterms   = 3'd4;
        nlast    = 4'd15;
        cov_addr = {pr_k, pr_l};
        mul_a    = pr_ok ? cov_rd : '0;
        mul_raw  = 1'b1;
      end
      ST_DET: begin
        engine = 1'b1;
        if (step_q[0]) begin
          mul_a   = s01_q;
          mul_b   = s10_q;
          mul_neg = 1'b1;
        end else begin
          mul_a = s00_q;
          mul_b = s11_q;
        end
      end
      ST_GAIN: begin
        engine   = 1'b1;
        nlast    = 4'd7;
        cov_addr = {elem_q[2:1], 1'b0, step_q[0]};
        mul_a    = cov_rd;
        mul_b    = inv_q[{step_q[0], elem_q[0]}];
      end
      ST_FEND: begin
        engine  = 1'b1;
        nterms  = 3'd3;
        nlast   = 4'd15;
        mul_neg = (step_q != 3'd0);
        case (step_q)
          3'd0: begin
            cov_addr = elem_q;
            mul_a    = cov_rd;
            mul_raw  = 1'b1;
          end
          3'd1: begin
            gain_addr = {elem_q[3:2], 1'b0};
            cov_addr  = {2'b00, elem_q[1:0]};
            mul_a     = gain_rd;
            mul_b     = cov_rd;
          end
          default: begin
            gain_addr = {elem_q[3:2], 1'b1};
            cov_addr  = {2'b01, elem_q[1:0]};
            mul_a     = gain_rd;
            mul_b     = cov_rd;
          end
        endcase
      end
      ST_GATE: begin
        engine  = 1'b1;
        nterms  = 3'd3;
        mul_raw = 1'b1;
        case (step_q)
          3'd0: begin
            mul_a = dx_q;
            mul_b = dx_q;
          end
          3'd1: begin
            mul_a = dy_q;
            mul_b = dy_q;
          end
          default: begin
            mul_a   = {1'b0, gate_q};
            mul_b   = {1'b0, gate_q};
            mul_neg = 1'b1;
          end
        endcase
      end
      ST_CORR: begin
        engine = 1'b1;
        nterms = 3'd3;
        nlast  = 4'd3;
        case (step_q)
          3'd0: begin
            mul_a   = x_q[elem_q[1:0]];
            mul_raw = 1'b1;
          end
          3'd1: begin
            gain_addr = {elem_q[1:0], 1'b0};
            mul_a     = gain_rd;
            mul_b     = -dx_q;
          end
          default: begin
            gain_addr = {elem_q[1:0], 1'b1};
            mul_a     = gain_rd;
            mul_b     = -dy_q;
          end
        endcase
      end
      default: begin
        engine = 1'b0;
      end
    endcase
  end

  // Divider numerator and one restoring step.
  logic signed [32:0] num;
  logic [32:0]        num_mag;
  logic [DW:0]        div_sh;
  logic               div_ge;
  logic [DW:0]        div_sub;
  logic signed [31:0] q_sat;

  always_comb begin
    case (div_k_q)
      2'd0:    num = 33'(s11_q);
      2'd1:    num = -33'(s01_q);
      2'd2:    num = -33'(s10_q);
      default: num = 33'(s00_q);
    endcase
    num_mag = num[32] ? 33'(-num) : 33'(num);
    div_sh  = {rem_q, dq_q[NW-1]};
    div_ge  = div_sh >= {1'b0, dmag_q};
    div_sub = div_sh - {1'b0, dmag_q};
    if (qneg_q) begin
      q_sat = (dq_q > Q_NEG_MAX) ? 32'sh8000_0000 : 32'(-dq_q[31:0]);
    end else begin
      q_sat = (dq_q > Q_POS_MAX) ? 32'sh7FFF_FFFF : 32'(dq_q[31:0]);
    end
  end

  // Target prediction and the box part of the gate.
  logic signed [32:0] px_sum, py_sum;
  logic signed [33:0] dx_full, dy_full, g_full;
  logic               in_box;

  assign px_sum  = 33'(in_data_i.pos_x) + 33'(in_data_i.vel_x);
  assign py_sum  = 33'(in_data_i.pos_y) + 33'(in_data_i.vel_y);
  assign dx_full = 34'(x_q[0]) - 34'(item_q.meas_x);
  assign dy_full = 34'(x_q[1]) - 34'(item_q.meas_y);
  assign g_full  = {3'b000, gate_q};
  assign in_box  = (dx_full <= g_full) && (dx_full >= -g_full) &&
                   (dy_full <= g_full) && (dy_full >= -g_full);

  logic [7:0] miss_next;
  assign miss_next = matched_q ? 8'd0 :
                     (item_q.miss_count == 8'hFF) ? 8'hFF : item_q.miss_count + 8'd1;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q  <= GATE_RST;
      maxm_q  <= '0;
      accv_q  <= VAR_RST;
      measv_q <= VAR_RST;
    end else if (cfg_wr) begin
      case (ktu_pkg::reg_e'(paddr[3:2]))
        ktu_pkg::REG_GATE:     gate_q  <= pwdata[30:0];
        ktu_pkg::REG_MAXMISS:  maxm_q  <= pwdata[7:0];
        ktu_pkg::REG_ACCELVAR: accv_q  <= pwdata[30:0];
        ktu_pkg::REG_MEASVAR:  measv_q <= pwdata[30:0];
        default:               maxm_q  <= maxm_q;
      endcase
    end
  end

  always_comb begin
    case (ktu_pkg::reg_e'(paddr[3:2]))
      ktu_pkg::REG_GATE:     prdata = {1'b0, gate_q};
      ktu_pkg::REG_MAXMISS:  prdata = {24'd0, maxm_q};
      ktu_pkg::REG_ACCELVAR: prdata = {1'b0, accv_q};
      ktu_pkg::REG_MEASVAR:  prdata = {1'b0, measv_q};
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      elem_q      <= '0;
      step_q      <= '0;
      div_k_q     <= '0;
      cnt_q       <= '0;
      matched_q   <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cov_q[i] <= noise_w(4'(i), VAR_RST);
      end
      for (int i = 0; i < 8; i++) begin
        gain_q[i] <= '0;
      end
    end else begin
      // The output state reloads the valid flag itself.
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;

      if (engine) begin
        if (step_q < nterms) begin
          prod_q <= prod_d;
          raw_q  <= mul_raw;
          neg_q  <= mul_neg;
        end
        if (step_q == 3'd0) acc_q <= '0;
        else if (step_q <= nterms) acc_q <= acc_next;
        if (step_q == nterms + 3'd1) begin
          step_q <= '0;
          elem_q <= (elem_q == nlast) ? 4'd0 : elem_q + 4'd1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            elem_q <= '0;
            step_q <= '0;
            case (ktu_pkg::kind_e'(in_data_i.kind))
              ktu_pkg::KIND_BEGIN: state_q <= ST_PRED;
              ktu_pkg::KIND_TARGET: begin
                x_q[0]  <= sat32(66'(px_sum));
                x_q[1]  <= sat32(66'(py_sum));
                x_q[2]  <= in_data_i.vel_x;
                x_q[3]  <= in_data_i.vel_y;
                state_q <= ST_PREP;
              end
              ktu_pkg::KIND_END: begin
                state_q <= in_data_i.had_detections ? ST_FEND : ST_IDLE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PREP: begin
          dx_q      <= dx_full[31:0];
          dy_q      <= dy_full[31:0];
          matched_q <= 1'b0;
          state_q   <= (item_q.has_measurement && in_box) ? ST_GATE : ST_OUT;
        end
        ST_GATE: begin
          if (step_q == nterms + 3'd1) begin
            matched_q <= (acc_q <= 66'sd0);
            state_q   <= (acc_q <= 66'sd0) ? ST_CORR : ST_OUT;
          end
        end
        ST_CORR: begin
          if (step_q == nterms + 3'd1) begin
            x_q[elem_q[1:0]] <= sat32(acc_q);
            if (elem_q == nlast) state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.new_pos_x      <= x_q[0];
            out_q.new_pos_y      <= x_q[1];
            out_q.new_vel_x      <= x_q[2];
            out_q.new_vel_y      <= x_q[3];
            out_q.matched        <= matched_q;
            out_q.new_miss_count <= miss_next;
            out_q.drop           <= miss_next > maxm_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        ST_PRED: begin
          if (step_q == nterms + 3'd1) begin
            tmp_q[elem_q] <= sat32(66'(sat32(acc_q)) + 66'(noise_w(elem_q, accv_q)));
            if (elem_q == nlast) state_q <= ST_COPYP;
          end
        end
        ST_COPYP: begin
          for (int i = 0; i < 16; i++) begin
            cov_q[i] <= tmp_q[i];
          end
          state_q <= ST_SCALC;
        end
        ST_SCALC: begin
          s00_q   <= sat32(66'(cov_q[0]) + 66'({1'b0, measv_q}));
          s01_q   <= cov_q[1];
          s10_q   <= cov_q[4];
          s11_q   <= sat32(66'(cov_q[5]) + 66'({1'b0, measv_q}));
          state_q <= ST_DET;
        end
        ST_DET: begin
          if (step_q == nterms + 3'd1) begin
            det_neg_q <= acc_q[65];
            dmag_q    <= acc_q[65] ? DW'(-acc_q) : DW'(acc_q);
            div_k_q   <= '0;
            if (acc_q == 66'sd0) begin
              // A singular innovation matrix leaves no usable gain.
              for (int i = 0; i < 8; i++) begin
                gain_q[i] <= '0;
              end
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_DIVLD;
            end
          end
        end
        ST_DIVLD: begin
          dq_q    <= {num_mag, {FRAC_BITS{1'b0}}};
          rem_q   <= '0;
          cnt_q   <= CW'(NW);
          qneg_q  <= num[32] ^ det_neg_q;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          dq_q  <= {dq_q[NW-2:0], div_ge};
          rem_q <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) state_q <= ST_DIVST;
        end
        ST_DIVST: begin
          inv_q[div_k_q] <= q_sat;
          div_k_q        <= div_k_q + 2'd1;
          state_q        <= (div_k_q == 2'd3) ? ST_GAIN : ST_DIVLD;
        end
        ST_GAIN: begin
          if (step_q == nterms + 3'd1) begin
            gain_q[elem_q[2:0]] <= sat32(acc_q);
            if (elem_q == nlast) state_q <= ST_IDLE;
          end
        end
        ST_FEND: begin
          if (step_q == nterms + 3'd1) begin
            tmp_q[elem_q] <= sat32(acc_q);
            if (elem_q == nlast) state_q <= ST_COPYE;
          end
        end
        ST_COPYE: begin
          for (int i = 0; i < 16; i++) begin
            cov_q[i] <= tmp_q[i];
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_match_clears_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.matched |-> out_data_o.new_miss_count == 8'd0)
    else $error("matched result with nonzero miss count");

  a_drop_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.drop == (out_data_o.new_miss_count > maxm_q))
    else $error("drop flag disagrees with miss count");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> dmag_q != '0)
    else $error("divider running on a zero determinant");

  a_busy_after_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == 2'(ktu_pkg::KIND_TARGET)
      |=> !in_ready_o)
    else $error("target item did not occupy the sequencer");
`endif

endmodule

`default_nettype wire

// ===== tb/ktu_checker.sv =====
// ----------------------------------------------------------------------------
// ktu_checker
// Watches the item channels and the register port of the Kalman track update
// block, predicts each target result and compares it with what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module ktu_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire ktu_pkg::in_t               in_data_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire ktu_pkg::out_t              out_data_i,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ktu_pkg::APB_AW-1:0] paddr,
  input  wire logic [ktu_pkg::APB_DW-1:0] pwdata,
  input  wire logic                       pready,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int  FRAC = 16;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  longint gate_q, accel_q, meas_q;
  int unsigned max_miss_q;
  longint cov[16];
  longint kgain[8];
  ktu_pkg::out_t track_q[$];
  int     fails;

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Arithmetic shift of a signed 64-bit product rounds toward minus infinity.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint noise_at(int idx, longint a);
    case (idx)
      0, 5:          return a >>> 2;
      10, 15:        return a;
      2, 7, 8, 13:   return a >>> 1;
      default:       return 0;
    endcase
  endfunction

  task automatic predict_frame_begin();
    longint p[16];
    longint acc, s00, s01, s10, s11, det;
    longint inv[4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = r; k < 4; k += 2) begin
          if (k != r && r >= 2) break;
          for (int l = c; l < 4; l += 2) begin
            if (l != c && c >= 2) break;
            acc += cov[k*4 + l];
          end
        end
        p[r*4 + c] = sat32(sat32(acc) + noise_at(r*4 + c, accel_q));
      end
    end
    for (int i = 0; i < 16; i++) cov[i] = p[i];
    s00 = sat32(p[0] + meas_q);
    s01 = p[1];
    s10 = p[4];
    s11 = sat32(p[5] + meas_q);
    det = qmul(s00, s11) - qmul(s01, s10);
    if (det == 0) begin
      for (int i = 0; i < 8; i++) kgain[i] = 0;
    end else begin
      inv[0] = sat32((s11 * (64'sd1 << FRAC)) / det);
      inv[1] = sat32((-s01 * (64'sd1 << FRAC)) / det);
      inv[2] = sat32((-s10 * (64'sd1 << FRAC)) / det);
      inv[3] = sat32((s00 * (64'sd1 << FRAC)) / det);
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 2; j++)
          kgain[i*2 + j] = sat32(qmul(p[i*4], inv[j]) + qmul(p[i*4 + 1], inv[2 + j]));
    end
  endtask

  task automatic predict_frame_end();
    longint p[16];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        p[i*4 + j] = sat32(cov[i*4 + j] - qmul(kgain[i*2], cov[j])
                           - qmul(kgain[i*2 + 1], cov[4 + j]));
    for (int i = 0; i < 16; i++) cov[i] = p[i];
  endtask

  function automatic ktu_pkg::out_t predict_track(ktu_pkg::in_t it);
    ktu_pkg::out_t res;
    longint st[4], nx[4];
    longint dx, dy;
    longint unsigned d2;
    logic   hit;
    int unsigned miss;
    st[2] = longint'(it.vel_x);
    st[3] = longint'(it.vel_y);
    st[0] = sat32(longint'(it.pos_x) + st[2]);
    st[1] = sat32(longint'(it.pos_y) + st[3]);
    hit = 1'b0;
    if (it.has_measurement) begin
      dx = st[0] - longint'(it.meas_x);
      dy = st[1] - longint'(it.meas_y);
      if (dx <= gate_q && -dx <= gate_q && dy <= gate_q && -dy <= gate_q) begin
        d2 = longint'(dx * dx) + longint'(dy * dy);
        if (d2 <= longint'(gate_q * gate_q)) hit = 1'b1;
      end
      if (hit) begin
        for (int i = 0; i < 4; i++)
          nx[i] = sat32(st[i] + qmul(kgain[i*2], -dx) + qmul(kgain[i*2 + 1], -dy));
        for (int i = 0; i < 4; i++) st[i] = nx[i];
      end
    end
    miss = 32'(it.miss_count);
    if (hit) miss = 0;
    else if (miss < 255) miss++;
    res.new_pos_x      = st[0][31:0];
    res.new_pos_y      = st[1][31:0];
    res.new_vel_x      = st[2][31:0];
    res.new_vel_y      = st[3][31:0];
    res.matched        = hit;
    res.new_miss_count = miss[7:0];
    res.drop           = (miss > max_miss_q);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ktu_pkg::out_t exp_res;
    if (!rst_ni) begin
      gate_q     = 64'd20 << FRAC;
      max_miss_q = 0;
      accel_q    = 64'd25 << (FRAC - 2);
      meas_q     = 64'd25 << (FRAC - 2);
      for (int i = 0; i < 16; i++) cov[i] = noise_at(i, accel_q);
      for (int i = 0; i < 8; i++) kgain[i] = 0;
      track_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ktu_pkg::reg_e'(paddr[3:2]))
          ktu_pkg::REG_GATE:     gate_q     = longint'(pwdata[30:0]);
          ktu_pkg::REG_MAXMISS:  max_miss_q = 32'(pwdata[7:0]);
          ktu_pkg::REG_ACCELVAR: accel_q    = longint'(pwdata[30:0]);
          ktu_pkg::REG_MEASVAR:  meas_q     = longint'(pwdata[30:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (track_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", out_data_i);
        end else begin
          exp_res = track_q.pop_front();
          if (out_data_i !== exp_res) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p got %p", exp_res, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.kind)
          ktu_pkg::KIND_BEGIN:  predict_frame_begin();
          ktu_pkg::KIND_TARGET: track_q.insert(track_q.size(), predict_track(in_data_i));
          ktu_pkg::KIND_END:    if (in_data_i.had_detections) predict_frame_end();
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= track_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/kalman_track_update_tb.sv =====
// ----------------------------------------------------------------------------
// kalman_track_update_tb
// Drives frames of target items through the track update block under random
// flow control and register settings; a checker module scores the results.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_track_update_tb;

  localparam int LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ktu_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ktu_pkg::out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ktu_pkg::APB_AW-1:0] paddr = '0;
  logic [ktu_pkg::APB_DW-1:0] pwdata = '0;
  logic [ktu_pkg::APB_DW-1:0] prdata;
  logic pready;
  int   fail_count, pending;
  int   cycles = 0;
  int   sent = 0;
  logic hold_off = 1'b0;
  longint gate_now = 64'd20 << 16;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  kalman_track_update uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ktu_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL kalman_track_update");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off once 120 items have been sent.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 9) < 6 || (sent > 300 && sent < 380)) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 19) == 0) ? 1'b1 : 1'b0;
  end

  initial begin
    wait (sent >= 120);
    hold_off = 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic send(input ktu_pkg::in_t item);
    int g;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    g = gap_len();
    if (sent > 300 && sent < 380) g = 0;
    if (g > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic reg_write(input ktu_pkg::reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ktu_pkg::APB_AW'(idx) << 2;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ktu_pkg::REG_GATE) gate_now = longint'(value[30:0]);
  endtask

  // Frame items leave no result behind, so wait out the slowest one too.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (500) @(negedge clk_i);
  endtask

  function automatic ktu_pkg::in_t frame_item(input ktu_pkg::kind_e k, input logic det);
    ktu_pkg::in_t it;
    it = '0;
    it.kind = k;
    it.had_detections = det;
    return it;
  endfunction

  function automatic ktu_pkg::in_t target_item(input longint px, input longint vx,
                                               input longint py, input longint vy,
                                               input logic has, input longint mx,
                                               input longint my, input int miss);
    ktu_pkg::in_t it;
    it = '0;
    it.kind = ktu_pkg::KIND_TARGET;
    it.pos_x = px[31:0];
    it.pos_y = py[31:0];
    it.vel_x = vx[31:0];
    it.vel_y = vy[31:0];
    it.has_measurement = has;
    it.meas_x = mx[31:0];
    it.meas_y = my[31:0];
    it.miss_count = miss[7:0];
    return it;
  endfunction

  function automatic ktu_pkg::in_t random_raw();
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(ktu_pkg::in_t)-1:0];
  endfunction

  function automatic longint srand(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  function automatic ktu_pkg::in_t random_target();
    ktu_pkg::in_t it;
    longint px, py, vx, vy, span;
    if ($urandom_range(0, 9) == 0) begin
      it = random_raw();
      it.kind = ktu_pkg::KIND_TARGET;
      return it;
    end
    px = srand(1 << 26);
    py = srand(1 << 26);
    vx = srand(1 << 20);
    vy = srand(1 << 20);
    span = gate_now + gate_now / 4 + 2;
    if (span > (1 << 28)) span = 1 << 28;
    return target_item(px, vx, py, vy, $urandom_range(0, 4) != 0,
                       px + vx + srand(int'(span)), py + vy + srand(int'(span)),
                       $urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 8));
  endfunction

  task automatic random_frames(input int count);
    int n;
    ktu_pkg::in_t it;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 19) == 0) begin
        it = random_raw();
        it.kind = ktu_pkg::KIND_RSVD;
        send(it);
      end
      send(frame_item(ktu_pkg::KIND_BEGIN, 1'b0));
      repeat ($urandom_range(1, 8)) begin
        send(random_target());
        n++;
      end
      send(frame_item(ktu_pkg::KIND_END, $urandom_range(0, 3) != 0));
      if ($urandom_range(0, 29) == 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: zero gain, gate of twenty pixels, max misses zero.
    send(target_item(100 << 16, 1 << 16, -5 << 16, 2 << 16, 1'b0, 0, 0, 0));
    send(target_item(0, 0, 0, 0, 1'b1, 0, 0, 7));
    send(target_item(0, 0, 0, 0, 1'b1, 20 << 16, 0, 255));
    send(target_item(0, 0, 0, 0, 1'b1, (20 << 16) + 1, 0, 3));
    send(target_item(0, 0, 0, 0, 1'b1, 15 << 16, 15 << 16, 3));
    send(target_item(64'sd2147483647, 64'sd1 << 20, -64'sd2147483648, -64'sd5,
                     1'b0, 0, 0, 254));
    send(target_item(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                     64'sd2147483647, 1'b1, 64'sd2147483647, -64'sd2147483648, 255));
    send(frame_item(ktu_pkg::KIND_RSVD, 1'b1));
    send(frame_item(ktu_pkg::KIND_BEGIN, 1'b0));
    send(target_item(10 << 16, 1 << 16, 10 << 16, -1 << 16, 1'b1, 12 << 16, 8 << 16, 4));
    send(target_item(-3 << 16, 0, 7 << 16, 0, 1'b1, -2 << 16, 7 << 16, 0));
    send(frame_item(ktu_pkg::KIND_END, 1'b0));
    send(frame_item(ktu_pkg::KIND_BEGIN, 1'b0));
    send(target_item(50 << 16, 2 << 16, 50 << 16, 2 << 16, 1'b1, 55 << 16, 49 << 16, 1));
    send(frame_item(ktu_pkg::KIND_END, 1'b1));
    send(frame_item(ktu_pkg::KIND_BEGIN, 1'b0));
    send(target_item(0, 0, 0, 0, 1'b1, 3 << 16, -4 << 16, 9));
    send(frame_item(ktu_pkg::KIND_END, 1'b1));
    drain();

    random_frames(70);
    drain();

    reg_write(ktu_pkg::REG_GATE, 32'h7FFF_FFFF);
    reg_write(ktu_pkg::REG_MAXMISS, 32'd255);
    reg_write(ktu_pkg::REG_ACCELVAR, 32'h7FFF_FFFF);
    reg_write(ktu_pkg::REG_MEASVAR, 32'h7FFF_FFFF);
    random_frames(55);
    drain();

    reg_write(ktu_pkg::REG_GATE, 32'd0);
    reg_write(ktu_pkg::REG_MAXMISS, 32'd0);
    reg_write(ktu_pkg::REG_ACCELVAR, 32'd0);
    reg_write(ktu_pkg::REG_MEASVAR, 32'd0);
    random_frames(40);
    drain();

    reg_write(ktu_pkg::REG_GATE, 32'hFFFF_FFFF);
    reg_write(ktu_pkg::REG_MAXMISS, 32'd3);
    reg_write(ktu_pkg::REG_ACCELVAR, 32'h0001_0000);
    reg_write(ktu_pkg::REG_MEASVAR, 32'h8000_4000);
    random_frames(85);
    drain();

    reg_write(ktu_pkg::REG_GATE, $urandom_range(1 << 16, 1 << 24));
    reg_write(ktu_pkg::REG_MAXMISS, $urandom_range(1, 254));
    reg_write(ktu_pkg::REG_ACCELVAR, $urandom);
    reg_write(ktu_pkg::REG_MEASVAR, $urandom_range(1 << 12, 1 << 22));
    random_frames(120);

    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (500) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS kalman_track_update");
    end else begin
      $display("FAIL kalman_track_update");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ktu_pkg.sv
rtl/kalman_track_update.sv
tb/ktu_checker.sv
tb/kalman_track_update_tb.sv
